>>> hw/rtl/swtb_pkg.sv
// Shared types and constants for the stop-and-wait transmit buffer.
`default_nettype none

package swtb_pkg;

  localparam int SwtbBufBytes = 1024;

  localparam int FuncW   = 3;
  localparam int DataW   = 8;
  localparam int AckW    = 16;
  localparam int OffW    = 10;
  localparam int CountW  = 11;
  localparam int MssW    = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  localparam int InDataW  = 40;
  localparam int OutDataW = 48;

  localparam logic [CountW-1:0] CapReset = 11'd1024;
  localparam logic [MssW-1:0]   MssReset = 16'd536;

  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE   = 3'd0,
    FUNC_SEG_REQ = 3'd1,
    FUNC_ACK     = 3'd2,
    FUNC_RETX    = 3'd3,
    FUNC_READ    = 3'd4
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAPACITY = 1'b0,
    REG_MSS      = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REDUCE,
    S_ADDR,
    S_FETCH
  } state_t;

  // Input word, first field in the highest bits.
  typedef struct packed {
    logic [OffW-1:0]  byte_offset;
    logic [AckW-1:0]  ack_count;
    logic [DataW-1:0] data_byte;
  } in_word_t;

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic [CountW-1:0] writable_bytes;
    logic [CountW-1:0] bytes_in_flight;
    logic [DataW-1:0]  read_byte;
    logic [CountW-1:0] segment_length;
    logic              accepted;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/swtb_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module swtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stop_and_wait_tx_buffer.sv
// Transmit byte buffer for a stop-and-wait sender: byte store, head and fill tracking.
`default_nettype none

// Buffers outgoing bytes in a single-port RAM of BUF_BYTES entries addressed as
// a ring from a head pointer. Items (tuser = func) are taken one at a time: a
// write, segment request, ack or retransmit is executed in S_EXEC and its
// result registered once the output register is free; a segment byte read
// goes through S_EXEC, S_REDUCE (only when BUF_BYTES is below 1024, where the
// offset is first reduced modulo the store size by reciprocal multiplication),
// S_ADDR for the RAM read and S_FETCH. The next item is accepted while the
// result still waits in the output register. Every result word carries the
// in-flight byte count and the writable space after the item. No clearing pass
// follows reset; only bytes written since reset may be read back.
module stop_and_wait_tx_buffer
  import swtb_pkg::*;
#(
  parameter int BUF_BYTES = swtb_pkg::SwtbBufBytes
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // tdata: data_byte, ack_count, byte_offset (lowest first), zero padded
  input  wire logic [swtb_pkg::InDataW-1:0]      s_tdata,
  // tuser: func
  input  wire logic [swtb_pkg::FuncW-1:0]        s_tuser,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // tdata: accepted, segment_length, read_byte, bytes_in_flight,
  //        writable_bytes (lowest first), zero padded
  output logic [swtb_pkg::OutDataW-1:0]          m_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [swtb_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [swtb_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int IdxW   = $clog2(BUF_BYTES);
  localparam int SumW   = (IdxW > CountW ? IdxW : CountW) + 1;
  localparam int BufCap = BUF_BYTES > 2047 ? 2047 : BUF_BYTES;
  // Offset reduction modulo a small store: quotient by reciprocal multiplication,
  // exact for every offset below 1024.
  localparam int RedSteps = BUF_BYTES >= 1024 ? 0 : 1;
  localparam int RecipS   = 20;
  localparam int RecipM   = BUF_BYTES >= 1024 ? 0
                            : ((1 << RecipS) + BUF_BYTES - 1) / BUF_BYTES;

  state_t state, state_next;

  logic [CountW-1:0] cap;
  logic [MssW-1:0]   mss;
  logic [IdxW-1:0]   head;
  logic [CountW-1:0] fill;
  logic              busy;

  func_t             func;
  in_word_t          item;

  logic [OffW-1:0]        rem;
  logic [OffW-1:0]        quo;
  logic [OffW+RecipS-1:0] recip_prod;

  result_t           res;

  // Combinational datapath
  logic [CountW-1:0] cap_use;
  logic [CountW-1:0] space_now;
  logic              wr_ok;
  logic              req_ok;
  logic [CountW-1:0] seg_len;
  logic [CountW-1:0] ack_c;
  logic [SumW-1:0]   wr_sum, ack_sum, rd_sum;
  logic [IdxW-1:0]   wr_addr, head_adv, rd_addr;
  logic [IdxW-1:0]   head_n;
  logic [CountW-1:0] fill_n;
  logic              busy_n;
  logic [CountW-1:0] flight_n, writable_n;
  logic              out_free;
  logic              commit;
  logic              load_read;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_addr;
  logic [DataW-1:0]  ram_rdata;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = {{(OutDataW - $bits(result_t)){1'b0}}, res};

  assign cap_use   = cap > CountW'(BufCap) ? CountW'(BufCap) : cap;
  assign space_now = (!busy && cap_use > fill) ? cap_use - fill : '0;

  assign wr_ok  = (func == FUNC_WRITE) && (space_now != '0);
  assign req_ok = (func == FUNC_SEG_REQ) && !busy && (fill != '0);
  assign seg_len = ({{(MssW - CountW){1'b0}}, fill} < mss) ? fill : mss[CountW-1:0];
  assign ack_c   = (item.ack_count > {{(AckW - CountW){1'b0}}, fill})
                   ? fill : item.ack_count[CountW-1:0];

  // Every sum stays below twice the store size: one compare and subtract wraps it.
  assign wr_sum   = SumW'(head) + SumW'(fill);
  assign wr_addr  = wr_sum >= SumW'(BUF_BYTES) ? IdxW'(wr_sum - SumW'(BUF_BYTES))
                                                : IdxW'(wr_sum);
  assign ack_sum  = SumW'(head) + SumW'(ack_c);
  assign head_adv = ack_sum >= SumW'(BUF_BYTES) ? IdxW'(ack_sum - SumW'(BUF_BYTES))
                                                 : IdxW'(ack_sum);
  assign rd_sum   = SumW'(head) + SumW'(rem);
  assign rd_addr  = rd_sum >= SumW'(BUF_BYTES) ? IdxW'(rd_sum - SumW'(BUF_BYTES))
                                                : IdxW'(rd_sum);

  assign recip_prod = (OffW + RecipS)'(item.byte_offset) * (OffW + RecipS)'(RecipM);

  always_comb begin
    head_n = head;
    fill_n = fill;
    busy_n = busy;
    unique case (func)
      FUNC_WRITE: begin
        if (wr_ok) begin
          fill_n = fill + 1'b1;
        end
      end
      FUNC_SEG_REQ: begin
        if (req_ok) begin
          busy_n = 1'b1;
        end
      end
      FUNC_ACK: begin
        if (item.ack_count != '0) begin
          fill_n = fill - ack_c;
          head_n = (fill == ack_c) ? '0 : head_adv;
          busy_n = 1'b0;
        end
      end
      FUNC_RETX: begin
        busy_n = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign flight_n   = busy_n ? fill_n : '0;
  assign writable_n = (!busy_n && cap_use > fill_n) ? cap_use - fill_n : '0;

  // Next state and controls
  always_comb begin
    state_next = state;
    commit     = 1'b0;
    load_read  = 1'b0;
    ram_re     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func == FUNC_READ) begin
          state_next = (RedSteps == 0) ? S_ADDR : S_REDUCE;
        end else if (out_free) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REDUCE: begin
        state_next = S_ADDR;
      end
      S_ADDR: begin
        ram_re     = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        if (out_free) begin
          load_read  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign ram_we   = commit && wr_ok;
  assign ram_addr = (state == S_ADDR) ? rd_addr : wr_addr;

  swtb_ram #(
    .WIDTH (DataW),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (item.data_byte),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and buffer state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= CapReset;
      mss  <= MssReset;
      head <= '0;
      fill <= '0;
      busy <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CAPACITY: cap <= cfg_data[CountW-1:0];
          REG_MSS:      mss <= cfg_data;
          default: begin
          end
        endcase
      end
      if (commit) begin
        head <= head_n;
        fill <= fill_n;
        busy <= busy_n;
      end
    end
  end

  // Item latch and offset reduction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func <= func_t'(s_tuser);
      item <= in_word_t'(s_tdata[$bits(in_word_t)-1:0]);
    end
    if (state == S_EXEC) begin
      rem <= item.byte_offset;
      quo <= recip_prod[OffW+RecipS-1:RecipS];
    end else if (state == S_REDUCE) begin
      // Take off the quotient times the store size.
      rem <= rem - OffW'(quo * BUF_BYTES);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit || load_read) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.accepted        <= wr_ok;
      res.segment_length  <= req_ok ? seg_len : '0;
      res.read_byte       <= '0;
      res.bytes_in_flight <= flight_n;
      res.writable_bytes  <= writable_n;
    end else if (load_read) begin
      res.accepted        <= 1'b0;
      res.segment_length  <= '0;
      res.read_byte       <= ram_rdata;
      res.bytes_in_flight <= busy ? fill : '0;
      res.writable_bytes  <= space_now;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    {{(SumW - CountW){1'b0}}, fill} <= SumW'(BUF_BYTES))
    else $error("fill count exceeds store size");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (head == '0))
    else $error("head not rewound on empty buffer");

  a_flight_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.bytes_in_flight == '0 || res.writable_bytes == '0))
    else $error("space reported while a segment is in flight");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted word not executed");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_EXEC && !busy && out_free))
    else $error("store written outside a committed write");

endmodule

`default_nettype wire

>>> tb/tx_ring_check_pkg.sv
// Scoreboard for the stop-and-wait transmit buffer: ring tracking and result comparison.
package tx_ring_check_pkg;
  import swtb_pkg::*;

  class tx_ring_scoreboard;
    logic [DataW-1:0] ring [SwtbBufBytes];
    bit               ever_written [SwtbBufBytes];
    int               written_total;
    int               oldest;
    int               held;
    bit               seg_busy;
    int               cap_reg;
    int               mss_reg;
    int               errors;
    result_t          pending_results [$];

    function new();
      foreach (ever_written[i]) ever_written[i] = 1'b0;
      written_total = 0;
      oldest = 0;
      held = 0;
      seg_busy = 1'b0;
      cap_reg = int'(CapReset);
      mss_reg = int'(MssReset);
      errors = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CfgDataW-1:0] value);
      if (idx == REG_CAPACITY) begin
        cap_reg = int'(value[CountW-1:0]);
      end else begin
        mss_reg = int'(value);
      end
    endfunction

    function int free_space();
      int cap;
      cap = (cap_reg > SwtbBufBytes) ? SwtbBufBytes : cap_reg;
      if (seg_busy || cap <= held) return 0;
      return cap - held;
    endfunction

    // Pick an offset that lands on a byte written since reset; -1 if none exists.
    function int read_offset(int want);
      int pos;
      pos = (oldest + want) % SwtbBufBytes;
      if (ever_written[pos]) return want;
      if (held > 0) return $urandom_range(held - 1);
      if (written_total == 0) return -1;
      for (int i = 0; i < 32; i++) begin
        pos = $urandom_range(SwtbBufBytes - 1);
        if (ever_written[pos]) return (pos - oldest + SwtbBufBytes) % SwtbBufBytes;
      end
      for (pos = 0; pos < SwtbBufBytes; pos++) begin
        if (ever_written[pos]) break;
      end
      return (pos - oldest + SwtbBufBytes) % SwtbBufBytes;
    endfunction

    function result_t note_item(logic [FuncW-1:0] f, in_word_t w);
      result_t r;
      int      pos;
      int      freed;
      r = '0;
      case (f)
        FUNC_WRITE: begin
          if (free_space() > 0) begin
            pos = (oldest + held) % SwtbBufBytes;
            ring[pos] = w.data_byte;
            if (!ever_written[pos]) begin
              ever_written[pos] = 1'b1;
              written_total++;
            end
            held++;
            r.accepted = 1'b1;
          end
        end
        FUNC_SEG_REQ: begin
          if (!seg_busy && held != 0) begin
            r.segment_length = CountW'((held < mss_reg) ? held : mss_reg);
            seg_busy = 1'b1;
          end
        end
        FUNC_ACK: begin
          if (w.ack_count != '0) begin
            freed = int'(w.ack_count);
            if (freed > held) freed = held;
            held -= freed;
            oldest = (oldest + freed) % SwtbBufBytes;
            // empty ring restarts at the bottom
            if (held == 0) oldest = 0;
            seg_busy = 1'b0;
          end
        end
        FUNC_RETX: seg_busy = 1'b0;
        FUNC_READ: r.read_byte = ring[(oldest + int'(w.byte_offset)) % SwtbBufBytes];
        default: ;
      endcase
      r.bytes_in_flight = seg_busy ? CountW'(held) : '0;
      r.writable_bytes = CountW'(free_space());
      pending_results.push_back(r);
      return r;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [OutDataW-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
      compare_field("segment_length", 16'(want.segment_length), 16'(got.segment_length));
      compare_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
      compare_field("bytes_in_flight", 16'(want.bytes_in_flight), 16'(got.bytes_in_flight));
      compare_field("writable_bytes", 16'(want.writable_bytes), 16'(got.writable_bytes));
    endfunction
  endclass

endpackage

>>> tb/stop_and_wait_tx_buffer_tb.sv
// Testbench top for the stop-and-wait transmit buffer: directed and random stream traffic.
module stop_and_wait_tx_buffer_tb;
  import swtb_pkg::*;
  import tx_ring_check_pkg::*;

  localparam int CycleLimit      = 400000;
  localparam int BulkFill        = 600;
  localparam int FuncUnusedFirst = 5;
  localparam int FuncCodeLast    = (1 << FuncW) - 1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [FuncW-1:0]    s_tuser = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  tx_ring_scoreboard sb;
  result_t           last_result;
  int                send_idle_pct = 18;
  int                recv_idle_pct = 64;
  int                items_sent = 0;
  int unsigned       cycles = 0;

  stop_and_wait_tx_buffer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  // Offer one word and hold it until taken; returns at the next falling edge.
  task automatic send_word(input logic [FuncW-1:0] f, input logic [DataW-1:0] d,
                           input logic [AckW-1:0] a, input logic [OffW-1:0] o);
    in_word_t w;
    int       off;
    if (f == FUNC_READ) begin
      off = sb.read_offset(int'(o));
      if (off < 0) f = FUNC_RETX;
      else o = OffW'(off);
    end
    w.data_byte = d;
    w.ack_count = a;
    w.byte_offset = o;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= InDataW'(w);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_result = sb.note_item(f, w);
    if (int'(f) <= int'(FUNC_READ)) items_sent++;
    @(negedge clk);
  endtask

  // Drain all pending results before touching a register.
  task automatic write_register(input cfg_reg_t idx, input logic [CfgDataW-1:0] value);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic noise_item();
    logic [AckW-1:0] a;
    a = $urandom_range(1) ? AckW'($urandom_range(8)) : AckW'($urandom);
    send_word(FuncW'($urandom_range(FuncCodeLast)), DataW'($urandom), a, OffW'($urandom));
  endtask

  // Fill, request a segment, fetch some of it, then ack or retransmit.
  task automatic run_exchange(input int max_burst);
    int n;
    int len;
    int k;
    int amount;
    int choice;
    n = $urandom_range(max_burst);
    repeat (n) send_word(FUNC_WRITE, DataW'($urandom), AckW'($urandom), OffW'($urandom));
    send_word(FUNC_SEG_REQ, DataW'($urandom), AckW'($urandom), OffW'($urandom));
    len = int'(last_result.segment_length);
    k = (len < 6) ? len : $urandom_range(1, 6);
    for (int i = 0; i < k; i++) begin
      send_word(FUNC_READ, DataW'($urandom), AckW'($urandom),
                OffW'((len <= 6) ? i : $urandom_range(len - 1)));
    end
    // a zero grant still leaves data in flight: ack past the fill to free it
    amount = (len != 0) ? len : sb.held + 1;
    choice = $urandom_range(9);
    case (choice)
      6: send_word(FUNC_ACK, DataW'($urandom), AckW'($urandom_range(1, amount)), OffW'($urandom));
      7: send_word(FUNC_ACK, DataW'($urandom), AckW'($urandom), OffW'($urandom));
      8: begin
        send_word(FUNC_ACK, DataW'($urandom), '0, OffW'($urandom));
        send_word(FUNC_ACK, DataW'($urandom), AckW'(amount), OffW'($urandom));
      end
      9: begin
        send_word(FUNC_RETX, DataW'($urandom), AckW'($urandom), OffW'($urandom));
        send_word(FUNC_SEG_REQ, DataW'($urandom), AckW'($urandom), OffW'($urandom));
        send_word(FUNC_ACK, DataW'($urandom), AckW'(amount), OffW'($urandom));
      end
      default: send_word(FUNC_ACK, DataW'($urandom), AckW'(amount), OffW'($urandom));
    endcase
  endtask

  task automatic run_phase(input int cap, input int mss, input int items,
                           input int max_burst, input int bulk);
    int start;
    write_register(REG_CAPACITY, CfgDataW'(cap));
    write_register(REG_MSS, CfgDataW'(mss));
    repeat (bulk) send_word(FUNC_WRITE, DataW'($urandom), AckW'($urandom), OffW'($urandom));
    start = items_sent;
    while (items_sent - start < items) begin
      if ($urandom_range(4) == 0) noise_item();
      else run_exchange(max_burst);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    write_register(REG_CAPACITY, CfgDataW'(CapReset));
    write_register(REG_MSS, MssReset);
    // empty ring: no grant, zero ack, oversized ack, retransmit, unused codes
    send_word(FUNC_SEG_REQ, '0, '0, '0);
    send_word(FUNC_ACK, '0, '0, '0);
    send_word(FUNC_ACK, '0, '1, '0);
    send_word(FUNC_RETX, '0, '0, '0);
    for (int u = FuncUnusedFirst; u <= FuncCodeLast; u++) send_word(FuncW'(u), '1, '1, '1);
    send_word(FUNC_WRITE, 8'h00, '0, '0);
    send_word(FUNC_WRITE, 8'hFF, '0, '0);
    send_word(FUNC_WRITE, 8'hA5, '0, '0);
    send_word(FUNC_READ, '0, '0, 10'd0);
    send_word(FUNC_READ, '0, '0, 10'd2);
    send_word(FUNC_SEG_REQ, '0, '0, '0);
    // busy: write dropped, second request refused
    send_word(FUNC_WRITE, 8'h5A, '0, '0);
    send_word(FUNC_SEG_REQ, '0, '0, '0);
    send_word(FUNC_READ, '0, '0, 10'd1);
    send_word(FUNC_RETX, '0, '0, '0);
    send_word(FUNC_SEG_REQ, '0, '0, '0);
    send_word(FUNC_ACK, '0, 16'd1, '0);
    send_word(FUNC_READ, '0, '0, 10'd0);
    // capacity below fill
    write_register(REG_CAPACITY, 16'd1);
    send_word(FUNC_WRITE, 8'h11, '0, '0);
    // zero segment size: grant nothing but still go busy
    write_register(REG_MSS, 16'd0);
    send_word(FUNC_ACK, '0, '1, '0);
    send_word(FUNC_WRITE, 8'h3C, '0, '0);
    send_word(FUNC_WRITE, 8'hC3, '0, '0);
    send_word(FUNC_SEG_REQ, '0, '0, '0);
    send_word(FUNC_ACK, '0, 16'd5, '0);
    write_register(REG_CAPACITY, 16'd0);
    send_word(FUNC_WRITE, 8'h77, '0, '0);
    // capacity beyond the store clamps to the store
    write_register(REG_CAPACITY, 16'd2047);
    send_word(FUNC_WRITE, 8'h88, '0, '0);

    run_phase(1024, 536, 150, 24, BulkFill);
    run_phase(2047, 65535, 120, 40, 0);
    send_idle_pct = 64;
    recv_idle_pct = 18;
    run_phase(5, 3, 120, 8, 0);
    run_phase(300, 0, 120, 24, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1, 1, 100, 3, 0);
    run_phase($urandom_range(1, 1024), $urandom_range(1, 65535), 120, 32, 0);
    s_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> stop_and_wait_tx_buffer.f
hw/rtl/swtb_pkg.sv
hw/rtl/swtb_ram.sv
hw/rtl/stop_and_wait_tx_buffer.sv
tb/tx_ring_check_pkg.sv
tb/stop_and_wait_tx_buffer_tb.sv
